[sv/bsas_pkg.sv]
// Shared types, codes and helpers for the seek/arrive steering block.
// No dependencies; used by the ALU, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package bsas_pkg;

  localparam int unsigned AluW     = 66;  // widest intermediate (sum of two squares)
  localparam int unsigned RemW     = 36;  // root / division remainder width
  localparam int unsigned CntW     = 6;
  localparam logic [CntW-1:0] LastStep = 6'd32;

  typedef enum logic [1:0] {
    OP_SEEK   = 2'd0,
    OP_ARRIVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_MAX_SPEED    = 3'd0,
    REG_MAX_FORCE    = 3'd1,
    REG_EDGE_MARGIN  = 3'd2,
    REG_FIELD_WIDTH  = 3'd3,
    REG_FIELD_HEIGHT = 3'd4,
    REG_SLOW_RADIUS  = 3'd5
  } reg_idx_t;

  typedef enum logic [18:0] {
    ST_IDLE  = 19'h00001,
    ST_DIFF  = 19'h00002,
    ST_SQX   = 19'h00004,
    ST_SQY   = 19'h00008,
    ST_SQRT  = 19'h00010,
    ST_CHK   = 19'h00020,
    ST_MMUL  = 19'h00040,
    ST_MDIV  = 19'h00080,
    ST_XSET  = 19'h00100,
    ST_XMUL  = 19'h00200,
    ST_XDIV  = 19'h00400,
    ST_XAPP  = 19'h00800,
    ST_YMUL  = 19'h01000,
    ST_YDIV  = 19'h02000,
    ST_YAPP  = 19'h04000,
    ST_TVEL  = 19'h08000,
    ST_TPOS  = 19'h10000,
    ST_TWRAP = 19'h20000,
    ST_DONE  = 19'h40000
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh07FFFFFFF)       r = 32'h7FFFFFFF;
    else if (v < -34'sh080000000) r = 32'h80000000;
    else                          r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
                                                 input logic [30:0] m);
    logic signed [33:0] mp;
    logic signed [33:0] r;
    mp = $signed({3'b000, m});
    if (v > mp)       r = mp;
    else if (v < -mp) r = -mp;
    else              r = v;
    return r;
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

endpackage

[sv/bsas_if.sv]
// Valid/ready channel interfaces for the steering block's input and result items.
// Depends on nothing beyond the package order; one transfer when valid and ready are high.
`timescale 1ns / 1ps

interface bsas_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] target_x;
  logic [31:0] target_y;
  modport source (output valid, operation, target_x, target_y, input ready);
  modport sink   (input valid, operation, target_x, target_y, output ready);
endinterface

interface bsas_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pos_x;
  logic [31:0] out_pos_y;
  logic [31:0] out_vel_x;
  logic [31:0] out_vel_y;
  logic [31:0] out_acc_x;
  logic [31:0] out_acc_y;
  modport source (output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                  out_acc_x, out_acc_y, input ready);
  modport sink   (input valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                  out_acc_x, out_acc_y, output ready);
endinterface

[sv/bsas_alu.sv]
// Shared add/subtract unit used for every multiply, root and divide step.
// Depends on bsas_pkg for the datapath width.
`timescale 1ns / 1ps

module bsas_alu (
  input  logic [bsas_pkg::AluW-1:0] a,
  input  logic [bsas_pkg::AluW-1:0] b,
  input  logic                      sub,
  output logic [bsas_pkg::AluW-1:0] result,
  output logic                      no_borrow
);
  logic [bsas_pkg::AluW:0] full;

  // With sub set, the carry out is high exactly when a >= b.
  assign full      = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{bsas_pkg::AluW{1'b0}}, sub};
  assign result    = full[bsas_pkg::AluW-1:0];
  assign no_borrow = full[bsas_pkg::AluW];
endmodule

[sv/boid_seek_arrive_steering.sv]
// Top level of the seek/arrive steering agent: sequencer, state and output register.
// Depends on bsas_pkg, bsas_in_if / bsas_out_if and bsas_alu.
//
//   channel  direction  payload
//   in_ch    in         operation, target_x, target_y
//   out_ch   out        out_pos_x/y, out_vel_x/y, out_acc_x/y
//   cfg_*    in         cfg_index, cfg_data (write only)
//
// In a seek or arrive item all squares, the root, and the divides go one bit
// per cycle through the single shared add/subtract unit; an arrive item inside
// the slow radius adds a scaling multiply and divide. A tick updates velocity,
// position and edge wrap in turn. One item is worked on at a time; the next is taken
// once the sequencer is idle, even while a result waits in the output register.
// Reset is synchronous and clears the agent state and the registers to defaults.
`timescale 1ns / 1ps

module boid_seek_arrive_steering #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  bsas_in_if.sink           in_ch,
  bsas_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [30:0]       cfg_data
);
  localparam int unsigned W  = bsas_pkg::AluW;
  localparam int unsigned RW = bsas_pkg::RemW;
  localparam int unsigned WXW = 15 + FRAC_BITS + 2;

  localparam logic [30:0] RstMaxSpeed  = 31'(64'd4 << FRAC_BITS);
  localparam logic [30:0] RstMaxForce  = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0] RstEdge      = 31'(64'd3 << FRAC_BITS);
  localparam logic [30:0] RstSlow      = 31'(64'd100 << FRAC_BITS);

  // Configuration
  logic [30:0] max_speed_r, max_force_r, edge_margin_r, slow_radius_r;
  logic [14:0] field_width_r, field_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r    <= RstMaxSpeed;
      max_force_r    <= RstMaxForce;
      edge_margin_r  <= RstEdge;
      field_width_r  <= 15'd1024;
      field_height_r <= 15'd768;
      slow_radius_r  <= RstSlow;
    end else if (cfg_we) begin
      case (bsas_pkg::reg_idx_t'(cfg_index))
        bsas_pkg::REG_MAX_SPEED:    max_speed_r    <= cfg_data;
        bsas_pkg::REG_MAX_FORCE:    max_force_r    <= cfg_data;
        bsas_pkg::REG_EDGE_MARGIN:  edge_margin_r  <= cfg_data;
        bsas_pkg::REG_FIELD_WIDTH:  field_width_r  <= cfg_data[14:0];
        bsas_pkg::REG_FIELD_HEIGHT: field_height_r <= cfg_data[14:0];
        bsas_pkg::REG_SLOW_RADIUS:  slow_radius_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  bsas_pkg::state_t state_r, state_nxt;
  bsas_pkg::op_t    op_r, op_nxt;
  logic [31:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [32:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [31:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [31:0] vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt;
  logic [31:0] acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic [W-1:0]  accum_r, accum_nxt, ma_r, ma_nxt;
  logic [32:0]   mb_r, mb_nxt, root_r, root_nxt, d_r, d_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [30:0]   mag_r, mag_nxt;
  logic [bsas_pkg::CntW-1:0] cnt_r, cnt_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [31:0] o_px_r, o_py_r, o_vx_r, o_vy_r, o_ax_r, o_ay_r;
  logic        out_load;

  // Shared unit
  logic [W-1:0] alu_a, alu_b, alu_res;
  logic         alu_sub, alu_ge;

  bsas_alu u_alu (
    .a         (alu_a),
    .b         (alu_b),
    .sub       (alu_sub),
    .result    (alu_res),
    .no_borrow (alu_ge)
  );

  logic [RW-1:0] sq_rem_sh, dv_rem_sh;
  logic [32:0]   div_d;
  logic          in_mul, in_div, last;

  assign sq_rem_sh = {rem_r[RW-3:0], accum_r[W-1:W-2]};
  assign dv_rem_sh = {rem_r[RW-2:0], accum_r[63]};
  assign div_d     = (state_r == bsas_pkg::ST_MDIV) ? {2'b00, slow_radius_r} : d_r;
  assign in_mul    = (state_r == bsas_pkg::ST_SQX) || (state_r == bsas_pkg::ST_SQY) ||
                     (state_r == bsas_pkg::ST_MMUL) || (state_r == bsas_pkg::ST_XMUL) ||
                     (state_r == bsas_pkg::ST_YMUL);
  assign in_div    = (state_r == bsas_pkg::ST_MDIV) || (state_r == bsas_pkg::ST_XDIV) ||
                     (state_r == bsas_pkg::ST_YDIV);
  assign last      = (cnt_r == bsas_pkg::LastStep);

  always_comb begin
    alu_a   = accum_r;
    alu_b   = ma_r;
    alu_sub = 1'b0;
    if (state_r == bsas_pkg::ST_SQRT) begin
      alu_a   = W'(sq_rem_sh);
      alu_b   = W'({root_r, 2'b01});
      alu_sub = 1'b1;
    end else if (in_div) begin
      alu_a   = W'(dv_rem_sh);
      alu_b   = W'(div_d);
      alu_sub = 1'b1;
    end
  end

  // Per-axis force application and tick arithmetic
  logic [32:0]        ax_abs, ay_abs;
  logic signed [31:0] q_signed;
  logic signed [33:0] f_axis, acc_sum, vsum_x, vsum_y, vcl_x, vcl_y;
  logic signed [33:0] psum_x, psum_y;
  logic signed [32:0] neg_m;
  logic signed [WXW-1:0] wx, hy, px_e, py_e, negm_e;
  logic               is_y;

  assign ax_abs = bsas_pkg::abs33(dx_r);
  assign ay_abs = bsas_pkg::abs33(dy_r);
  assign is_y   = (state_r == bsas_pkg::ST_YAPP);

  always_comb begin
    logic [31:0] qmag;
    qmag     = {1'b0, root_r[30:0]};
    q_signed = ((is_y ? dy_r[32] : dx_r[32])) ? -$signed(qmag) : $signed(qmag);
    f_axis   = bsas_pkg::clamp34(34'(q_signed) -
                                 34'($signed(is_y ? vel_y_r : vel_x_r)), max_force_r);
    acc_sum  = 34'($signed(is_y ? acc_y_r : acc_x_r)) + f_axis;
  end

  assign vsum_x = 34'($signed(vel_x_r)) + 34'($signed(acc_x_r));
  assign vsum_y = 34'($signed(vel_y_r)) + 34'($signed(acc_y_r));
  assign vcl_x  = bsas_pkg::clamp34(vsum_x, max_speed_r);
  assign vcl_y  = bsas_pkg::clamp34(vsum_y, max_speed_r);
  assign psum_x = 34'($signed(pos_x_r)) + 34'($signed(vel_x_r));
  assign psum_y = 34'($signed(pos_y_r)) + 34'($signed(vel_y_r));

  assign neg_m  = -$signed({2'b00, edge_margin_r});
  assign negm_e = WXW'(neg_m);
  assign wx     = $signed((WXW'(field_width_r) << FRAC_BITS) + WXW'(edge_margin_r));
  assign hy     = $signed((WXW'(field_height_r) << FRAC_BITS) + WXW'(edge_margin_r));
  assign px_e   = WXW'($signed(pos_x_r));
  assign py_e   = WXW'($signed(pos_y_r));

  function automatic logic [31:0] sat_edge(input logic signed [WXW-1:0] v);
    return (v > WXW'(32'sh7FFFFFFF)) ? 32'h7FFFFFFF : v[31:0];
  endfunction

  assign in_ch.ready = (state_r == bsas_pkg::ST_IDLE);
  assign out_load    = (state_r == bsas_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    vel_x_nxt = vel_x_r;
    vel_y_nxt = vel_y_r;
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    accum_nxt = accum_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    d_nxt     = d_r;
    mag_nxt   = mag_r;
    cnt_nxt   = cnt_r + 1'b1;

    // Shift-and-add multiply step common to all product states.
    if (in_mul) begin
      if (mb_r[0]) accum_nxt = alu_res;
      ma_nxt = {ma_r[W-2:0], 1'b0};
      mb_nxt = {1'b0, mb_r[32:1]};
    end

    // Restoring divide: first cycle loads the upper half of the dividend.
    if (in_div) begin
      if (cnt_r == '0) begin
        rem_nxt   = RW'(accum_r[63:32]);
        accum_nxt = {accum_r[W-1:64], accum_r[31:0], 32'd0};
        root_nxt  = '0;
      end else begin
        rem_nxt   = alu_ge ? alu_res[RW-1:0] : dv_rem_sh;
        root_nxt  = {root_r[31:0], alu_ge};
        accum_nxt = {accum_r[W-1:64], accum_r[62:0], 1'b0};
      end
    end

    case (state_r)
      bsas_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt = bsas_pkg::op_t'(in_ch.operation);
          tx_nxt = in_ch.target_x;
          ty_nxt = in_ch.target_y;
          case (bsas_pkg::op_t'(in_ch.operation))
            bsas_pkg::OP_SEEK, bsas_pkg::OP_ARRIVE: state_nxt = bsas_pkg::ST_DIFF;
            bsas_pkg::OP_TICK:                      state_nxt = bsas_pkg::ST_TVEL;
            default:                                state_nxt = bsas_pkg::ST_DONE;
          endcase
        end
      end
      bsas_pkg::ST_DIFF: begin
        dx_nxt    = 33'($signed(tx_r)) - 33'($signed(pos_x_r));
        dy_nxt    = 33'($signed(ty_r)) - 33'($signed(pos_y_r));
        state_nxt = bsas_pkg::ST_SQX;
        accum_nxt = '0;
        ma_nxt    = W'(bsas_pkg::abs33(dx_nxt));
        mb_nxt    = bsas_pkg::abs33(dx_nxt);
        cnt_nxt   = '0;
      end
      bsas_pkg::ST_SQX: begin
        if (last) begin
          ma_nxt    = W'(ay_abs);
          mb_nxt    = ay_abs;
          cnt_nxt   = '0;
          state_nxt = bsas_pkg::ST_SQY;
        end
      end
      bsas_pkg::ST_SQY: begin
        if (last) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = bsas_pkg::ST_SQRT;
        end
      end
      bsas_pkg::ST_SQRT: begin
        rem_nxt   = alu_ge ? alu_res[RW-1:0] : sq_rem_sh;
        root_nxt  = {root_r[31:0], alu_ge};
        accum_nxt = {accum_r[W-3:0], 2'b00};
        if (last) state_nxt = bsas_pkg::ST_CHK;
      end
      bsas_pkg::ST_CHK: begin
        d_nxt   = root_r;
        cnt_nxt = '0;
        if (root_r == '0) begin
          state_nxt = bsas_pkg::ST_DONE;
        end else if (op_r == bsas_pkg::OP_ARRIVE && root_r < {2'b00, slow_radius_r}) begin
          accum_nxt = '0;
          ma_nxt    = W'(max_speed_r);
          mb_nxt    = root_r;
          state_nxt = bsas_pkg::ST_MMUL;
        end else begin
          mag_nxt   = max_speed_r;
          state_nxt = bsas_pkg::ST_XSET;
        end
      end
      bsas_pkg::ST_MMUL: begin
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = bsas_pkg::ST_MDIV;
        end
      end
      bsas_pkg::ST_MDIV: begin
        if (last) state_nxt = bsas_pkg::ST_XSET;
      end
      bsas_pkg::ST_XSET: begin
        if (op_r == bsas_pkg::OP_ARRIVE && d_r < {2'b00, slow_radius_r})
          mag_nxt = root_r[30:0];
        accum_nxt = '0;
        ma_nxt    = W'(ax_abs);
        mb_nxt    = {2'b00, mag_nxt};
        cnt_nxt   = '0;
        state_nxt = bsas_pkg::ST_XMUL;
      end
      bsas_pkg::ST_XMUL: begin
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = bsas_pkg::ST_XDIV;
        end
      end
      bsas_pkg::ST_XDIV: begin
        if (last) state_nxt = bsas_pkg::ST_XAPP;
      end
      bsas_pkg::ST_XAPP: begin
        acc_x_nxt = bsas_pkg::sat32(acc_sum);
        accum_nxt = '0;
        ma_nxt    = W'(ay_abs);
        mb_nxt    = {2'b00, mag_r};
        cnt_nxt   = '0;
        state_nxt = bsas_pkg::ST_YMUL;
      end
      bsas_pkg::ST_YMUL: begin
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = bsas_pkg::ST_YDIV;
        end
      end
      bsas_pkg::ST_YDIV: begin
        if (last) state_nxt = bsas_pkg::ST_YAPP;
      end
      bsas_pkg::ST_YAPP: begin
        acc_y_nxt = bsas_pkg::sat32(acc_sum);
        state_nxt = bsas_pkg::ST_DONE;
      end
      bsas_pkg::ST_TVEL: begin
        vel_x_nxt = vcl_x[31:0];
        vel_y_nxt = vcl_y[31:0];
        state_nxt = bsas_pkg::ST_TPOS;
      end
      bsas_pkg::ST_TPOS: begin
        pos_x_nxt = bsas_pkg::sat32(psum_x);
        pos_y_nxt = bsas_pkg::sat32(psum_y);
        acc_x_nxt = '0;
        acc_y_nxt = '0;
        state_nxt = bsas_pkg::ST_TWRAP;
      end
      bsas_pkg::ST_TWRAP: begin
        // Wrapping below lands on the far edge, never beyond it, so at most
        // one of the two tests per axis fires.
        if (px_e < negm_e)  pos_x_nxt = sat_edge(wx);
        else if (px_e > wx) pos_x_nxt = neg_m[31:0];
        if (py_e < negm_e)  pos_y_nxt = sat_edge(hy);
        else if (py_e > hy) pos_y_nxt = neg_m[31:0];
        state_nxt = bsas_pkg::ST_DONE;
      end
      bsas_pkg::ST_DONE: begin
        if (out_load) state_nxt = bsas_pkg::ST_IDLE;
      end
      default: state_nxt = bsas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (out_load)     out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsas_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      vel_x_r     <= vel_x_nxt;
      vel_y_r     <= vel_y_nxt;
      acc_x_r     <= acc_x_nxt;
      acc_y_r     <= acc_y_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    tx_r    <= tx_nxt;
    ty_r    <= ty_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    accum_r <= accum_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    root_r  <= root_nxt;
    rem_r   <= rem_nxt;
    d_r     <= d_nxt;
    mag_r   <= mag_nxt;
    if (out_load) begin
      o_px_r <= pos_x_r;
      o_py_r <= pos_y_r;
      o_vx_r <= vel_x_r;
      o_vy_r <= vel_y_r;
      o_ax_r <= acc_x_r;
      o_ay_r <= acc_y_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_pos_x = o_px_r;
  assign out_ch.out_pos_y = o_py_r;
  assign out_ch.out_vel_x = o_vx_r;
  assign out_ch.out_vel_y = o_vy_r;
  assign out_ch.out_acc_x = o_ax_r;
  assign out_ch.out_acc_y = o_ay_r;

  // The desired speed never exceeds the speed limit.
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bsas_pkg::ST_XMUL |-> mag_r <= max_speed_r)
    else $error("desired magnitude above max_speed");

  // Each scaled axis is no larger than the desired magnitude.
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsas_pkg::ST_XAPP || state_r == bsas_pkg::ST_YAPP)
      |-> (root_r[32:31] == 2'b00 && root_r[30:0] <= mag_r))
    else $error("axis quotient exceeds magnitude");

  // Right after the velocity update both axes sit within the limit.
  a_vel_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bsas_pkg::ST_TPOS |->
      ($signed(vel_x_r) <= $signed({1'b0, max_speed_r}) &&
       $signed(vel_x_r) >= -$signed({1'b0, max_speed_r}) &&
       $signed(vel_y_r) <= $signed({1'b0, max_speed_r}) &&
       $signed(vel_y_r) >= -$signed({1'b0, max_speed_r})))
    else $error("velocity outside max_speed after update");

  // An accepted item always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != bsas_pkg::ST_IDLE)
    else $error("accepted item did not start work");

  // A tick always leaves the acceleration cleared.
  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bsas_pkg::ST_TPOS |=> (acc_x_r == '0 && acc_y_r == '0))
    else $error("tick did not clear acceleration");

endmodule

[dv/boid_seek_arrive_steering_checker.sv]
// Checker for the seek/arrive steering block: watches both channels and the
// configuration port, predicts each result and compares it field by field.
// Depends on bsas_pkg and the channel interfaces in sv/bsas_if.sv.
`timescale 1ns / 1ps

module boid_seek_arrive_steering_checker (
  input  logic        clk,
  input  logic        rst_n,
  bsas_in_if          in_ch,
  bsas_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic signed [31:0] px, py, vx, vy, ax, ay;
  } agent_t;

  agent_t agent_q[$];

  logic signed [63:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  logic [63:0] max_speed, max_force, edge_margin, field_w, field_h, slow_radius;

  function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] limit(input logic signed [63:0] v,
                                               input logic [63:0] m);
    logic signed [63:0] ms;
    ms = $signed(m);
    if (v > ms) return ms;
    if (v < -ms) return -ms;
    return v;
  endfunction

  // Root of the full 66-bit sum of squares, one result bit per pass.
  function automatic logic [63:0] root_of(input logic [65:0] s);
    logic [65:0] root, rem, trial;
    root = '0;
    rem = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | ((s >> (2 * i)) & 66'd3);
      trial = (root << 2) | 66'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 66'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic logic signed [63:0] desired_axis(input logic signed [63:0] a,
                                                      input logic [63:0] mag,
                                                      input logic [63:0] d);
    logic [63:0] ua, q;
    ua = (a < 0) ? -a : a;
    q = (ua * mag) / d;
    return (a < 0) ? -$signed(q) : $signed(q);
  endfunction

  task automatic apply_steer(input logic signed [63:0] tx, input logic signed [63:0] ty,
                             input bit slowing);
    logic signed [63:0] dx, dy, fx, fy;
    logic [65:0] sq;
    logic [63:0] d, mag, ux, uy;
    dx = tx - pos_x;
    dy = ty - pos_y;
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    sq = 66'(ux) * 66'(ux) + 66'(uy) * 66'(uy);
    d = root_of(sq);
    mag = max_speed;
    if (d != 0) begin
      if (slowing && d < slow_radius) mag = (max_speed * d) / slow_radius;
      fx = limit(desired_axis(dx, mag, d) - vel_x, max_force);
      fy = limit(desired_axis(dy, mag, d) - vel_y, max_force);
      acc_x = sat_word(acc_x + fx);
      acc_y = sat_word(acc_y + fy);
    end
  endtask

  task automatic apply_tick();
    logic signed [63:0] m, wx, hy;
    m = $signed(edge_margin);
    wx = $signed(field_w << 16) + m;
    hy = $signed(field_h << 16) + m;
    vel_x = limit(vel_x + acc_x, max_speed);
    vel_y = limit(vel_y + acc_y, max_speed);
    pos_x = sat_word(pos_x + vel_x);
    pos_y = sat_word(pos_y + vel_y);
    acc_x = 0;
    acc_y = 0;
    if (pos_x < -m) pos_x = sat_word(wx);
    if (pos_y < -m) pos_y = sat_word(hy);
    if (pos_x > wx) pos_x = -m;
    if (pos_y > hy) pos_y = -m;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    agent_t e, got;
    if (!rst_n) begin
      pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0; acc_x = 0; acc_y = 0;
      max_speed = 64'd262144;
      max_force = 64'd6554;
      edge_margin = 64'd196608;
      field_w = 64'd1024;
      field_h = 64'd768;
      slow_radius = 64'd6553600;
      fail_count = 0;
      agent_q.delete();
      pending_count = 0;
    end else begin
      if (cfg_we) begin
        case (bsas_pkg::reg_idx_t'(cfg_index))
          bsas_pkg::REG_MAX_SPEED:    max_speed = cfg_data;
          bsas_pkg::REG_MAX_FORCE:    max_force = cfg_data;
          bsas_pkg::REG_EDGE_MARGIN:  edge_margin = cfg_data;
          bsas_pkg::REG_FIELD_WIDTH:  field_w = cfg_data[14:0];
          bsas_pkg::REG_FIELD_HEIGHT: field_h = cfg_data[14:0];
          bsas_pkg::REG_SLOW_RADIUS:  slow_radius = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        case (bsas_pkg::op_t'(in_ch.operation))
          bsas_pkg::OP_SEEK:
            apply_steer($signed(in_ch.target_x), $signed(in_ch.target_y), 1'b0);
          bsas_pkg::OP_ARRIVE:
            apply_steer($signed(in_ch.target_x), $signed(in_ch.target_y), 1'b1);
          bsas_pkg::OP_TICK:
            apply_tick();
          default: ;
        endcase
        e.px = pos_x[31:0]; e.py = pos_y[31:0];
        e.vx = vel_x[31:0]; e.vy = vel_y[31:0];
        e.ax = acc_x[31:0]; e.ay = acc_y[31:0];
        agent_q.push_back(e);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_pos_x, out_ch.out_pos_y, out_ch.out_vel_x,
               out_ch.out_vel_y, out_ch.out_acc_x, out_ch.out_acc_y};
        if (agent_q.size() == 0) begin
          $error("result transfer with no expected result waiting");
          fail_count++;
        end else begin
          e = agent_q.pop_front();
          check_field("out_pos_x", e.px, got.px);
          check_field("out_pos_y", e.py, got.py);
          check_field("out_vel_x", e.vx, got.vx);
          check_field("out_vel_y", e.vy, got.vy);
          check_field("out_acc_x", e.ax, got.ax);
          check_field("out_acc_y", e.ay, got.ay);
        end
      end
      pending_count = agent_q.size();
    end
  end

endmodule

[dv/boid_seek_arrive_steering_tb.sv]
// Testbench top for the seek/arrive steering block: clock, reset, stimulus,
// register writes and the verdict. Depends on bsas_pkg, the channel
// interfaces, the block and boid_seek_arrive_steering_checker.
`timescale 1ns / 1ps

module boid_seek_arrive_steering_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;
  int          fail_count;
  int          pending_count;
  bit          hold_results = 1'b0;

  bsas_in_if  in_ch ();
  bsas_out_if out_ch ();

  boid_seek_arrive_steering DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  boid_seek_arrive_steering_checker checker_inst (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int g;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_results && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (3000) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ch.ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_item(input bsas_pkg::op_t op, input logic [31:0] tx,
                           input logic [31:0] ty, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.target_x <= tx;
    in_ch.target_y <= ty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(input bsas_pkg::reg_idx_t idx, input logic [30:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
      default: return 32'($signed($urandom_range(0, 2400000)) - 300000);
    endcase
  endfunction

  task automatic random_items(input int n);
    int r;
    bsas_pkg::op_t op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      op = r < 35 ? bsas_pkg::OP_SEEK : r < 70 ? bsas_pkg::OP_ARRIVE :
           r < 97 ? bsas_pkg::OP_TICK : bsas_pkg::OP_NONE;
      send_item(op, rand_coord(), rand_coord(), 1'b1);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = bsas_pkg::OP_SEEK;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: target on the position, extremes, every operation code.
    send_item(bsas_pkg::OP_SEEK, 32'h0, 32'h0, 1'b0);
    send_item(bsas_pkg::OP_ARRIVE, 32'h0, 32'h0, 1'b0);
    send_item(bsas_pkg::OP_SEEK, 32'h7FFFFFFF, 32'h80000000, 1'b0);
    send_item(bsas_pkg::OP_ARRIVE, 32'h00100000, 32'hFFF00000, 1'b0);
    send_item(bsas_pkg::OP_ARRIVE, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    send_item(bsas_pkg::OP_TICK, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    send_item(bsas_pkg::OP_NONE, 32'h12345678, 32'h9ABCDEF0, 1'b0);
    send_item(bsas_pkg::OP_SEEK, 32'h80000000, 32'h80000000, 1'b0);
    repeat (4) send_item(bsas_pkg::OP_TICK, 32'h0, 32'h0, 1'b0);
    drain();

    // Extreme registers: saturation and wrap at the largest field.
    write_reg(bsas_pkg::REG_MAX_SPEED, 31'h7FFFFFFF);
    write_reg(bsas_pkg::REG_MAX_FORCE, 31'h7FFFFFFF);
    write_reg(bsas_pkg::REG_EDGE_MARGIN, 31'h7FFFFFFF);
    write_reg(bsas_pkg::REG_FIELD_WIDTH, 31'h7FFF);
    write_reg(bsas_pkg::REG_FIELD_HEIGHT, 31'h7FFF);
    write_reg(bsas_pkg::REG_SLOW_RADIUS, 31'h7FFFFFFF);
    send_item(bsas_pkg::OP_SEEK, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
    send_item(bsas_pkg::OP_SEEK, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
    send_item(bsas_pkg::OP_TICK, 32'h0, 32'h0, 1'b0);
    send_item(bsas_pkg::OP_ARRIVE, 32'h80000000, 32'h80000000, 1'b0);
    send_item(bsas_pkg::OP_TICK, 32'h0, 32'h0, 1'b0);
    random_items(100);
    drain();

    // Slow radius of zero, small field, zero margin and zero limits.
    write_reg(bsas_pkg::REG_SLOW_RADIUS, 31'h0);
    write_reg(bsas_pkg::REG_EDGE_MARGIN, 31'h0);
    write_reg(bsas_pkg::REG_FIELD_WIDTH, 31'h1);
    write_reg(bsas_pkg::REG_FIELD_HEIGHT, 31'h1);
    write_reg(bsas_pkg::REG_MAX_SPEED, 31'h0);
    write_reg(bsas_pkg::REG_MAX_FORCE, 31'h0);
    random_items(40);
    drain();

    write_reg(bsas_pkg::REG_MAX_SPEED, 31'd262144);
    write_reg(bsas_pkg::REG_MAX_FORCE, 31'd65536);
    write_reg(bsas_pkg::REG_SLOW_RADIUS, 31'd6553600);
    write_reg(bsas_pkg::REG_FIELD_WIDTH, 31'd40);
    write_reg(bsas_pkg::REG_FIELD_HEIGHT, 31'd30);
    write_reg(bsas_pkg::REG_EDGE_MARGIN, 31'd65536);
    // Long stall on the result side while items keep coming.
    hold_results = 1'b1;
    random_items(200);
    drain();

    write_reg(bsas_pkg::REG_MAX_SPEED, 31'd1 << 24);
    write_reg(bsas_pkg::REG_MAX_FORCE, 31'd1 << 22);
    write_reg(bsas_pkg::REG_FIELD_WIDTH, 31'd1024);
    write_reg(bsas_pkg::REG_FIELD_HEIGHT, 31'd768);
    random_items(250);
    drain();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

endmodule
